// File: rtl/ordered_record_store_with_key_extract_top_macros.svh
// Assertion macros for the ordered record store checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef ORDERED_RECORD_STORE_WITH_KEY_EXTRACT_TOP_MACROS_SVH
`define ORDERED_RECORD_STORE_WITH_KEY_EXTRACT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORSK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ORSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/orsk_pkg.sv
// Shared types and constants of the ordered record store.
// No dependencies; imported by every module of the block.
`default_nettype none

package orsk_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // Head pointer plus record count, before the ring wrap.
  localparam int SUM_W   = CNT_W + 1;

  localparam int OP_W     = 2;
  localparam int ID_W     = 31;
  localparam int MAKER_W  = 16;
  localparam int SER_W    = 32;
  localparam int OUT_ID_W = 32;
  localparam int ST_W     = 2;
  localparam int FILL_W   = 5;

  localparam int IN_DATA_W    = ((ID_W + MAKER_W + SER_W + 7) / 8) * 8;
  localparam int OUT_FILL_LSB = OUT_ID_W + MAKER_W + SER_W;
  localparam int OUT_DATA_W   = ((OUT_FILL_LSB + FILL_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_EXTRACT    = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [MAKER_W-1:0] maker;
    logic [SER_W-1:0]   series;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic cap;         // latch the accepted item
    logic do_push;     // insert (or flag full) and set a no-record result
    logic set_miss;    // set the not-found result
    logic scan_start;  // read the head slot, reset the scan position
    logic rd_step;     // read the next slot, advance scan pointers
    logic take;        // capture the matching record and start removal
    logic shift_wr;    // move one record down by one slot
    logic load_out;    // copy the result into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic match;
    logic at_head;
    logic last_cmp;
    logic last_move;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/orsk_ctrl.sv
// Sequencing state machine of the ordered record store.
// Depends on orsk_pkg; drives the datapath through cmd_t, reads stat_t.
`default_nettype none

module orsk_ctrl import orsk_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_push || stat.empty) state_nxt = S_RESP;
        else                            state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.match) begin
          state_nxt = (stat.at_head || stat.last_cmp) ? S_RESP : S_SHIFT;
        end else if (stat.last_cmp) begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        if (stat.last_move) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.cap = in_tvalid;
      end
      S_EXEC: begin
        if (stat.is_push)    cmd.do_push    = 1'b1;
        else if (stat.empty) cmd.set_miss   = 1'b1;
        else                 cmd.scan_start = 1'b1;
      end
      S_SCAN: begin
        cmd.rd_step = 1'b1;
        if (stat.match)         cmd.take     = 1'b1;
        else if (stat.last_cmp) cmd.set_miss = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        cmd.rd_step  = 1'b1;
      end
      S_RESP: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out)  out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/orsk_datapath.sv
// Record memory, ring pointers, scan/shift counters and result registers.
// Depends on orsk_pkg; acts on cmd_t from orsk_ctrl and reports stat_t.
`default_nettype none

module orsk_datapath import orsk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OP_W-1:0]       in_op,
  input  rec_t                  in_rec,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [ST_W-1:0]       out_tuser
);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    if (p == '0) return PTR_W'(DEPTH - 1);
    return p - 1'b1;
  endfunction

  rec_t                mem_r [DEPTH];
  rec_t                rdata_r;

  op_t                 req_op_r;
  rec_t                req_rec_r;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, cmp_ptr_r, wr_ptr_r;
  logic [PTR_W-1:0]    cmp_pos_r, moves_r;

  logic [OUT_ID_W-1:0] res_id_r, out_id_r;
  logic [MAKER_W-1:0]  res_maker_r, out_maker_r;
  logic [SER_W-1:0]    res_series_r, out_series_r;
  status_t             res_status_r, out_status_r;
  logic [FILL_W-1:0]   out_fill_r;

  logic [SUM_W-1:0]    tail_sum;
  logic [PTR_W-1:0]    tail_addr, head_dec;
  logic                push_ok;
  logic                wr_en, rd_en;
  logic [PTR_W-1:0]    wr_addr, rd_addr;
  rec_t                wr_data;

  // Physical slot one past the last record.
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);
  assign head_dec  = ptr_dec(head_r);

  assign stat.is_push   = (req_op_r == OP_PUSH_FRONT) || (req_op_r == OP_PUSH_BACK);
  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.empty     = (count_r == '0);
  assign stat.match     = (req_op_r == OP_POP_FRONT) || (rdata_r.id == req_rec_r.id);
  assign stat.at_head   = (cmp_pos_r == '0);
  assign stat.last_cmp  = (CNT_W'(cmp_pos_r) == (count_r - CNT_W'(1)));
  assign stat.last_move = (moves_r == PTR_W'(1));

  assign push_ok = cmd.do_push && !stat.full;

  assign wr_en   = push_ok || cmd.shift_wr;
  assign wr_addr = cmd.shift_wr ? wr_ptr_r :
                   ((req_op_r == OP_PUSH_FRONT) ? head_dec : tail_addr);
  assign wr_data = cmd.shift_wr ? rdata_r : req_rec_r;

  assign rd_en   = cmd.scan_start || cmd.rd_step;
  assign rd_addr = cmd.scan_start ? head_r : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem_r[rd_addr];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + 1'b1;
      if (req_op_r == OP_PUSH_FRONT) head_nxt = head_dec;
    end
    if (cmd.take) begin
      // Drop the head by advancing it; a tail match only shrinks the count.
      if (stat.at_head) begin
        head_nxt  = ptr_inc(head_r);
        count_nxt = count_r - 1'b1;
      end else if (stat.last_cmp) begin
        count_nxt = count_r - 1'b1;
      end
    end
    if (cmd.shift_wr && stat.last_move) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_op_r  <= op_t'(in_op);
      req_rec_r <= in_rec;
    end
    if (cmd.scan_start) begin
      cmp_ptr_r <= head_r;
      cmp_pos_r <= '0;
      rd_ptr_r  <= ptr_inc(head_r);
    end
    if (cmd.rd_step) begin
      rd_ptr_r  <= ptr_inc(rd_ptr_r);
      cmp_ptr_r <= ptr_inc(cmp_ptr_r);
      cmp_pos_r <= cmp_pos_r + 1'b1;
    end
    if (cmd.take) begin
      wr_ptr_r     <= cmp_ptr_r;
      moves_r      <= PTR_W'(count_r - CNT_W'(cmp_pos_r) - CNT_W'(1));
      res_id_r     <= {1'b0, rdata_r.id};
      res_maker_r  <= rdata_r.maker;
      res_series_r <= rdata_r.series;
      res_status_r <= ST_OK;
    end
    if (cmd.shift_wr) begin
      wr_ptr_r <= ptr_inc(wr_ptr_r);
      moves_r  <= moves_r - 1'b1;
    end
    if (cmd.do_push || cmd.set_miss) begin
      res_id_r     <= '1;
      res_maker_r  <= '0;
      res_series_r <= '1;
      if (cmd.set_miss)       res_status_r <= ST_MISS;
      else if (stat.full)     res_status_r <= ST_FULL;
      else                    res_status_r <= ST_OK;
    end
    if (cmd.load_out) begin
      out_id_r     <= res_id_r;
      out_maker_r  <= res_maker_r;
      out_series_r <= res_series_r;
      out_status_r <= res_status_r;
      out_fill_r   <= FILL_W'(count_r);
    end
  end

  assign out_tdata = OUT_DATA_W'({out_fill_r, out_series_r, out_maker_r, out_id_r});
  assign out_tuser = out_status_r;

endmodule

`default_nettype wire

// File: rtl/ordered_record_store_with_key_extract_top.sv
// Ordered record store with remove-by-id (a bounded deque of DEPTH records).
// Each input transaction carries one operation and yields exactly one result
// transaction. The records live in a single-port-write, single-port-read ring
// memory with a head pointer and a record count; push-front and push-back
// just move the head or write past the tail, while extract-by-id scans slots
// from the head one per cycle and then closes the gap by moving each later
// record down one slot per cycle; a match at the head or at the last record
// needs no shift. One item is in work at a time; the next input transaction
// is accepted while the previous result still sits in the output register.
// The store needs no clearing after reset: only data read from slots holding
// records is used.
// Depends on orsk_pkg, orsk_ctrl and orsk_datapath.
`default_nettype none

module ordered_record_store_with_key_extract_top import orsk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [30:0] car_id, [46:31] maker_handle, [78:47] series_in, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] out_id, [47:32] out_maker, [79:48] out_series, [84:80] fill_level,
  // rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [ST_W-1:0]       out_tuser
);

  cmd_t  cmd;
  stat_t stat;
  rec_t  in_rec;

  // Unpack the input payload into a record.
  assign in_rec.id     = in_tdata[ID_W-1:0];
  assign in_rec.maker  = in_tdata[ID_W +: MAKER_W];
  assign in_rec.series = in_tdata[ID_W + MAKER_W +: SER_W];

  // Sequencer: handshakes, scan and shift control.
  orsk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Record memory, pointers and the output register.
  orsk_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (in_tuser),
    .in_rec    (in_rec),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/orsk_checker.sv
// Port-level checker for the ordered record store, bound to the top level.
// Depends on orsk_pkg and the assertion macro header.
`default_nettype none
`include "ordered_record_store_with_key_extract_top_macros.svh"

module orsk_checker import orsk_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [ST_W-1:0]       out_tuser
);

  // A stalled result holds its payload.
  `ORSK_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // One item in work at a time: no accept right after an accept.
  `ORSK_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input accepted back to back")

  // Only defined status codes leave the block.
  `ORSK_ASSERT_SAME(a_status_code, out_tvalid, (out_tuser == ST_OK) || (out_tuser == ST_MISS) || (out_tuser == ST_FULL), "undefined status code")

  // A miss or a dropped push carries the no-record pattern.
  `ORSK_ASSERT_SAME(a_no_record, out_tvalid && (out_tuser != ST_OK), (out_tdata[OUT_ID_W-1:0] == {OUT_ID_W{1'b1}}) && (out_tdata[OUT_ID_W +: MAKER_W] == '0) && (out_tdata[OUT_ID_W + MAKER_W +: SER_W] == {SER_W{1'b1}}), "bad no-record result")

  // A dropped push reports a full store.
  `ORSK_ASSERT_SAME(a_full_level, out_tvalid && (out_tuser == ST_FULL), out_tdata[OUT_FILL_LSB +: FILL_W] == FILL_W'(DEPTH), "full status with wrong fill level")

endmodule

bind ordered_record_store_with_key_extract_top orsk_checker u_orsk_checker (.*);

`default_nettype wire
